// ===== rtl/kfcd_pkg.sv =====
// kfcd_pkg: shared types and constants of the keyed frame checksum decoder
// used by kfcd_front, kfcd_queue, kfcd_back and the top level
`timescale 1ns / 1ps

package kfcd_pkg;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] CHAR_P     = 8'h70;
  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [5:0] CHECK_MASK = 6'h3f;

  localparam logic [7:0] KEY0_RESET = 8'd57;
  localparam logic [7:0] KEY1_RESET = 8'd57;
  localparam logic [7:0] KEY2_RESET = 8'd98;

  localparam logic [1:0] REG_KEY0 = 2'd0;
  localparam logic [1:0] REG_KEY1 = 2'd1;
  localparam logic [1:0] REG_KEY2 = 2'd2;

  // reciprocal constants for exact decimal split of a 16-bit value
  localparam logic [16:0] RECIP_1000 = 17'd67109;
  localparam int          SHIFT_1000 = 26;
  localparam logic [16:0] RECIP_100  = 17'd41;
  localparam int          SHIFT_100  = 12;
  localparam logic [16:0] RECIP_10   = 17'd205;
  localparam int          SHIFT_10   = 11;
  localparam logic [15:0] DIV_1000   = 16'd1000;
  localparam logic [15:0] DIV_100    = 16'd100;
  localparam logic [15:0] DIV_10     = 16'd10;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic        rep;
    logic [15:0] value;
    logic        has_byte;
    logic [7:0]  data_byte;
  } cmd_t;

endpackage

// ===== rtl/keyed_frame_checksum_decoder_top.sv =====
// keyed_frame_checksum_decoder_top: top level of the keyed frame checksum decoder
// depends on kfcd_pkg, kfcd_front, kfcd_queue and kfcd_back
//
// usage:
//   s_* stream carries received bytes (s_tdata = rx_byte). every accepted
//   transaction yields zero to six bytes on the m_* stream (m_tdata = tx_byte);
//   m_tlast marks the final byte caused by one input transaction.
//   key characters are set over the apb port at 0x0, 0x4, 0x8 (pready always high).
// echo path and throughput:
//   a plain echo passes the command queue and the output register before
//   it appears on m_tvalid; echoes sustain one transaction per cycle while
//   m_tready is high. a decoded-value report adds three digit steps
//   (reciprocal multiply, scale back, subtract) of the back end.
//   the command queue of QUEUE_DEPTH entries lets s_tready stay high while
//   the back end is busy or m_tready is low; s_tready drops only when full.
// reset:
//   rst is synchronous; it restores the default key and clears all control
//   state and the queue. no bytes are lost or repeated when the receiver stalls.
`timescale 1ns / 1ps

module keyed_frame_checksum_decoder_top #(
  parameter int QUEUE_DEPTH = kfcd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] tx_byte
  output logic        m_tlast
);

  logic           push, pop, full, empty;
  kfcd_pkg::cmd_t push_cmd, pop_cmd;

  kfcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  kfcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  kfcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ===== rtl/kfcd_front.sv =====
// kfcd_front: key registers, byte classification, frame capture and check
// depends on kfcd_pkg; pushes one command per transaction that has output
`timescale 1ns / 1ps

module kfcd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  output logic               push,
  output kfcd_pkg::cmd_t     push_cmd,
  input  logic               full
);

  logic [7:0]  key0, key1, key2;
  logic [1:0]  match_count, match_count_next;
  logic        key_found, key_found_next;
  logic        frame_ready, frame_ready_next;
  logic [1:0]  newline_count, newline_count_next;
  logic [1:0]  capture_index, capture_index_next;
  logic [7:0]  frame_bytes [4];
  logic [15:0] decoded_value, decoded_value_next;
  logic        report_pending, report_pending_next;

  logic        accept, wr_frame, is_nl, check_ok;
  logic [1:0]  m_base, m_inc;
  logic [7:0]  want;
  logic [9:0]  sum;
  logic [7:0]  d0, d1, d2;
  logic [15:0] decoded;

  assign pready   = 1'b1;
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign is_nl    = (in_byte == kfcd_pkg::CHAR_NL);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key0 <= kfcd_pkg::KEY0_RESET;
      key1 <= kfcd_pkg::KEY1_RESET;
      key2 <= kfcd_pkg::KEY2_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        kfcd_pkg::REG_KEY0: key0 <= pwdata[7:0];
        kfcd_pkg::REG_KEY1: key1 <= pwdata[7:0];
        kfcd_pkg::REG_KEY2: key2 <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      kfcd_pkg::REG_KEY0: prdata = {24'd0, key0};
      kfcd_pkg::REG_KEY1: prdata = {24'd0, key1};
      kfcd_pkg::REG_KEY2: prdata = {24'd0, key2};
      default:            prdata = 32'd0;
    endcase
  end

  // frame check and digit decode
  assign sum      = 10'(frame_bytes[0]) + 10'(frame_bytes[1]) + 10'(frame_bytes[2]);
  assign check_ok = ({2'b00, sum[5:0] & kfcd_pkg::CHECK_MASK} + kfcd_pkg::ASCII_ZERO)
                    == frame_bytes[3];
  assign d0 = frame_bytes[0] - kfcd_pkg::ASCII_ZERO;
  assign d1 = frame_bytes[1] - kfcd_pkg::ASCII_ZERO;
  assign d2 = frame_bytes[2] - kfcd_pkg::ASCII_ZERO;
  assign decoded = {d0[3:0], 12'd0} + {{2{d1[7]}}, d1, 6'd0} + {{8{d2[7]}}, d2};

  assign m_base = (match_count > 2'd2) ? 2'd0 : match_count;
  assign want   = (m_base == 2'd0) ? key0 : (m_base == 2'd1) ? key1 : key2;
  assign m_inc  = (in_byte == want) ? m_base + 2'd1 : 2'd0;

  always_comb begin
    match_count_next    = match_count;
    key_found_next      = key_found;
    frame_ready_next    = frame_ready;
    newline_count_next  = newline_count;
    capture_index_next  = capture_index;
    decoded_value_next  = decoded_value;
    report_pending_next = 1'b0;
    wr_frame            = 1'b0;
    push_cmd.rep        = report_pending;
    push_cmd.value      = decoded_value;
    push_cmd.has_byte   = 1'b0;
    push_cmd.data_byte  = 8'd0;
    if (frame_ready) begin
      push_cmd.has_byte  = 1'b1;
      push_cmd.data_byte = kfcd_pkg::CHAR_P;
      if (check_ok) begin
        decoded_value_next  = decoded;
        capture_index_next  = 2'd0;
        report_pending_next = 1'b1;
      end
      key_found_next   = 1'b0;
      frame_ready_next = 1'b0;
    end else if (!key_found) begin
      push_cmd.has_byte  = 1'b1;
      push_cmd.data_byte = 8'(m_inc) + kfcd_pkg::ASCII_ZERO;
      if (m_inc == 2'd3) begin
        key_found_next   = 1'b1;
        match_count_next = 2'd0;
      end else begin
        match_count_next = m_inc;
      end
    end else begin
      if (is_nl && newline_count != 2'd3) begin
        newline_count_next = newline_count + 2'd1;
      end
      if (newline_count_next < 2'd2) begin
        push_cmd.has_byte  = 1'b1;
        push_cmd.data_byte = 8'(newline_count_next) + kfcd_pkg::ASCII_ZERO;
      end
      if (newline_count_next == 2'd2 && !is_nl) begin
        wr_frame           = 1'b1;
        push_cmd.has_byte  = 1'b1;
        push_cmd.data_byte = in_byte;
        if (capture_index == 2'd3) begin
          frame_ready_next   = 1'b1;
          newline_count_next = 2'd0;
          capture_index_next = 2'd0;
        end else begin
          capture_index_next = capture_index + 2'd1;
        end
      end
    end
  end

  assign push = accept && (push_cmd.rep || push_cmd.has_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count    <= 2'd0;
      key_found      <= 1'b0;
      frame_ready    <= 1'b0;
      newline_count  <= 2'd0;
      capture_index  <= 2'd0;
      decoded_value  <= 16'd0;
      report_pending <= 1'b0;
    end else if (accept) begin
      match_count    <= match_count_next;
      key_found      <= key_found_next;
      frame_ready    <= frame_ready_next;
      newline_count  <= newline_count_next;
      capture_index  <= capture_index_next;
      decoded_value  <= decoded_value_next;
      report_pending <= report_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_frame) begin
      frame_bytes[capture_index] <= in_byte;
    end
  end

endmodule

// ===== rtl/kfcd_queue.sv =====
// kfcd_queue: small command fifo between front and back
// depends on kfcd_pkg for the command type
`timescale 1ns / 1ps

module kfcd_queue #(
  parameter int DEPTH = kfcd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kfcd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output kfcd_pkg::cmd_t pop_cmd,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  kfcd_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");

endmodule

// ===== rtl/kfcd_back.sv =====
// kfcd_back: turns commands into transmit bytes, with decimal report sequencer
// depends on kfcd_pkg; drives the registered output stream
`timescale 1ns / 1ps

module kfcd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  kfcd_pkg::cmd_t pop_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_last
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NL   = 4'd1;
  localparam logic [3:0] S_Q1   = 4'd2;
  localparam logic [3:0] S_E1   = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_Q2   = 4'd5;
  localparam logic [3:0] S_E2   = 4'd6;
  localparam logic [3:0] S_M3   = 4'd7;
  localparam logic [3:0] S_Q3   = 4'd8;
  localparam logic [3:0] S_E3   = 4'd9;
  localparam logic [3:0] S_E4   = 4'd10;
  localparam logic [3:0] S_BYTE = 4'd11;

  logic [3:0]  state;
  logic [15:0] value;
  logic        has_byte;
  logic [7:0]  data_byte;
  logic [32:0] prod;
  logic [6:0]  qreg;
  logic [15:0] qd;
  logic [9:0]  rem;

  logic        can_emit, emit, emit_last;
  logic [7:0]  emit_byte;
  logic [6:0]  q1;
  logic [3:0]  q2, q3;

  assign can_emit = !out_valid || out_ready;
  assign q1 = prod[kfcd_pkg::SHIFT_1000 +: 7];
  assign q2 = prod[kfcd_pkg::SHIFT_100 +: 4];
  assign q3 = prod[kfcd_pkg::SHIFT_10 +: 4];
  assign pop = (state == S_IDLE) && !empty && (pop_cmd.rep || can_emit);

  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_byte = 8'd0;
    case (state)
      S_IDLE: begin
        if (pop && !pop_cmd.rep) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_byte = pop_cmd.data_byte;
        end
      end
      S_NL: begin
        emit      = can_emit;
        emit_byte = kfcd_pkg::CHAR_NL;
      end
      S_E1, S_E2, S_E3: begin
        emit      = can_emit;
        emit_byte = 8'(qreg) + kfcd_pkg::ASCII_ZERO;
      end
      S_E4: begin
        emit      = can_emit;
        emit_last = !has_byte;
        emit_byte = 8'(rem) + kfcd_pkg::ASCII_ZERO;
      end
      S_BYTE: begin
        emit      = can_emit;
        emit_last = 1'b1;
        emit_byte = data_byte;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (pop && pop_cmd.rep) state <= S_NL;
        S_NL:   if (can_emit) state <= S_Q1;
        S_Q1:   state <= S_E1;
        S_E1:   if (can_emit) state <= S_M2;
        S_M2:   state <= S_Q2;
        S_Q2:   state <= S_E2;
        S_E2:   if (can_emit) state <= S_M3;
        S_M3:   state <= S_Q3;
        S_Q3:   state <= S_E3;
        S_E3:   if (can_emit) state <= S_E4;
        S_E4:   if (can_emit) state <= has_byte ? S_BYTE : S_IDLE;
        S_BYTE: if (can_emit) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // report datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (pop) begin
          value     <= pop_cmd.value;
          has_byte  <= pop_cmd.has_byte;
          data_byte <= pop_cmd.data_byte;
        end
      end
      S_NL: prod <= 33'(value) * 33'(kfcd_pkg::RECIP_1000);
      S_Q1: begin
        qreg <= q1;
        qd   <= 16'(16'(q1) * kfcd_pkg::DIV_1000);
      end
      S_E1: if (can_emit) rem <= 10'(value - qd);
      S_M2: prod <= 33'(rem) * 33'(kfcd_pkg::RECIP_100);
      S_Q2: begin
        qreg <= 7'(q2);
        qd   <= 16'(16'(q2) * kfcd_pkg::DIV_100);
      end
      S_E2: if (can_emit) rem <= rem - 10'(qd);
      S_M3: prod <= 33'(rem) * 33'(kfcd_pkg::RECIP_10);
      S_Q3: begin
        qreg <= 7'(q3);
        qd   <= 16'(16'(q3) * kfcd_pkg::DIV_10);
      end
      S_E3: if (can_emit) rem <= rem - 10'(qd);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= emit_byte;
      out_last <= emit_last;
    end
  end

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (state != S_IDLE))
    else $error("non-final byte with no run in progress");
  a_thousands_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_E1) |-> (qreg <= 7'd65))
    else $error("thousands digit out of range");

endmodule
